FILE: design/fpc_pkg.sv
// Shared constants, types and the CRC-8 byte update for the framed packet checker.
package fpc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Byte positions inside a frame header
  localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 17'd0;
  localparam logic [POS_W-1:0] POS_SYNC_SECOND = 17'd1;
  localparam logic [POS_W-1:0] POS_LEN_LOW     = 17'd2;
  localparam logic [POS_W-1:0] POS_LEN_HIGH    = 17'd3;
  localparam logic [POS_W-1:0] POS_MSG_ID      = 17'd4;
  localparam logic [POS_W-1:0] POS_CHECKSUM    = 17'd5;
  localparam logic [POS_W-1:0] HEADER_BYTES    = 17'd6;
  localparam logic [POS_W-1:0] POS_MAX         = {POS_W{1'b1}};

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // Check status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SIZE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   id;
    logic [LEN_W-1:0]    length;
  } result_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/fpc_frame.sv
// Per-frame state: byte counter, running CRC, header capture and status evaluation.
module fpc_frame (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [fpc_pkg::BYTE_W-1:0]     frame_byte,
  input  logic                           frame_end,
  input  logic [fpc_pkg::BYTE_W-1:0]     sync_first,
  input  logic [fpc_pkg::BYTE_W-1:0]     sync_second,
  output fpc_pkg::result_t               result
);
  import fpc_pkg::*;

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] running_crc, running_crc_next;
  logic              sync_bad, sync_bad_next;
  logic [LEN_W-1:0]  held_length, held_length_next;
  logic [BYTE_W-1:0] held_id, held_id_next;
  logic [BYTE_W-1:0] held_checksum, held_checksum_next;
  logic [POS_W-1:0]  expected_total;

  // Fold the current byte into the frame state
  always_comb begin
    running_crc_next   = running_crc;
    sync_bad_next      = sync_bad;
    held_length_next   = held_length;
    held_id_next       = held_id;
    held_checksum_next = held_checksum;
    unique case (byte_position)
      POS_SYNC_FIRST: begin
        if (frame_byte != sync_first) sync_bad_next = 1'b1;
      end
      POS_SYNC_SECOND: begin
        if (frame_byte != sync_second) sync_bad_next = 1'b1;
      end
      POS_LEN_LOW: begin
        held_length_next = {held_length[LEN_W-1:BYTE_W], frame_byte};
        running_crc_next = crc8_update(running_crc, frame_byte);
      end
      POS_LEN_HIGH: begin
        held_length_next = {frame_byte, held_length[BYTE_W-1:0]};
        running_crc_next = crc8_update(running_crc, frame_byte);
      end
      POS_MSG_ID: begin
        held_id_next     = frame_byte;
        running_crc_next = crc8_update(running_crc, frame_byte);
      end
      POS_CHECKSUM: begin
        held_checksum_next = frame_byte;
      end
      default: begin
        running_crc_next = crc8_update(running_crc, frame_byte);
      end
    endcase
    byte_position_next = (byte_position != POS_MAX) ? byte_position + 1'b1 : byte_position;
  end

  // Evaluate the status in priority order; length + 6 does not wrap at 17 bits
  assign expected_total = {1'b0, held_length_next} + HEADER_BYTES;

  always_comb begin
    if (byte_position_next < HEADER_BYTES) begin
      result.status = ST_SIZE;
      result.id     = '0;
      result.length = '0;
    end else begin
      if (sync_bad_next) begin
        result.status = ST_SYNC;
      end else if (held_id_next == '0) begin
        result.status = ST_ID;
      end else if (byte_position_next != expected_total) begin
        result.status = ST_SIZE;
      end else if (running_crc_next != held_checksum_next) begin
        result.status = ST_CRC;
      end else begin
        result.status = ST_OK;
      end
      result.id     = held_id_next;
      result.length = held_length_next;
    end
  end

  // Advance on each processed byte, clear at frame end
  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      byte_position <= '0;
      running_crc   <= CRC_INIT;
      sync_bad      <= 1'b0;
      held_length   <= '0;
      held_id       <= '0;
      held_checksum <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      sync_bad      <= sync_bad_next;
      held_length   <= held_length_next;
      held_id       <= held_id_next;
      held_checksum <= held_checksum_next;
    end
  end

endmodule

FILE: design/fpc_result_reg.sv
// Output register holding one checked-frame result until downstream takes it.
module fpc_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fpc_pkg::result_t  result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output fpc_pkg::result_t  result_out
);
  import fpc_pkg::*;

  logic valid_next;

  // Set on load, drop once the transaction completes
  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      valid_next = 1'b0;
    end else begin
      valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: design/framed_packet_checker_core.sv
// Top level of the framed packet checker: input register, frame logic, result register.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | frame_byte, frame_end
//  out     | out_valid/out_stall| check_status, message_id, payload_length
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low: each byte waits in the input register, where the
// frame state and the CRC-8 byte update take it; a frame-end byte's result is loaded into
// the output register on the edge at which that byte leaves the input register.
// Synchronous reset clears the frame state, sync registers and both valid flags.
// in_stall rises only when a frame-end byte waits in the input register behind an
// undelivered result; non-final bytes keep flowing under out_stall.
module framed_packet_checker_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fpc_pkg::BYTE_W-1:0]     frame_byte,
  input  logic                           frame_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fpc_pkg::STATUS_W-1:0]   check_status,
  output logic [fpc_pkg::BYTE_W-1:0]     message_id,
  output logic [fpc_pkg::LEN_W-1:0]      payload_length,
  input  logic                           cfg_we,
  input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpc_pkg::BYTE_W-1:0]     cfg_data
);
  import fpc_pkg::*;

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_end;
  logic              s1_advance;
  logic              in_accept;
  result_t           frame_result;
  result_t           held_result;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= '0;
      sync_second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register moves on unless a result has nowhere to go
  assign s1_advance = s1_valid && (!s1_end || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= frame_byte;
      s1_end  <= frame_end;
    end
  end

  fpc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .frame_byte  (s1_byte),
    .frame_end   (s1_end),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .result      (frame_result)
  );

  fpc_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_advance && s1_end),
    .result_in  (frame_result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (held_result)
  );

  assign check_status   = held_result.status;
  assign message_id     = held_result.id;
  assign payload_length = held_result.length;

endmodule

FILE: design/fpc_checker.sv
// Port-level assertions for the framed packet checker, bound to the top level.
module fpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fpc_pkg::STATUS_W-1:0]  check_status,
  input logic [fpc_pkg::BYTE_W-1:0]    message_id,
  input logic [fpc_pkg::LEN_W-1:0]     payload_length
);
  import fpc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(check_status) &&
      $stable(message_id) && $stable(payload_length))
    else $error("result changed while stalled");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> check_status <= ST_CRC)
    else $error("undefined status code");

  // Id-zero status and a passing frame agree with the reported id
  a_id_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (check_status == ST_ID || check_status == ST_OK) |->
      ((check_status == ST_ID) == (message_id == '0)))
    else $error("status disagrees with message id");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind framed_packet_checker_core fpc_checker u_fpc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .check_status   (check_status),
  .message_id     (message_id),
  .payload_length (payload_length)
);

FILE: test/tb.sv
// Self-checking testbench for the framed packet checker: scripted frames, random traffic.
module tb;
  import fpc_pkg::*;

  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              typed;
    result_t           want;
  } script_row_t;

  localparam result_t NONE = '0;

  // Scripted frames, sync registers at 00/00; typed reports are checked as written
  localparam script_row_t SCRIPT [31] = '{
    // one-byte frame
    '{8'h00, 1'b1, 1'b1, '{ST_SIZE, 8'h00, 16'h0000}},
    // clean minimal frame, CRC over 00 00 01 is 07
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h01, 1'b0, 1'b0, NONE},
    '{8'h07, 1'b1, 1'b1, '{ST_OK, 8'h01, 16'h0000}},
    // bad first sync byte
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b1, '{ST_SYNC, 8'hFF, 16'h0000}},
    // id zero
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b1, '{ST_ID, 8'h00, 16'h0000}},
    // maximum length field, frame far too short
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'hFF, 1'b0, 1'b0, NONE}, '{8'h80, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b1, '{ST_SIZE, 8'h80, 16'hFFFF}},
    // wrong checksum byte
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE}, '{8'h00, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b0, 1'b0, NONE}, '{8'h01, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b1, '{ST_CRC, 8'h01, 16'h0000}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    frame_byte = '0;
  logic                 frame_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  check_status;
  logic [BYTE_W-1:0]    message_id;
  logic [LEN_W-1:0]     payload_length;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  // Predictor copy of the configuration and frame state
  logic [BYTE_W-1:0] sync_first_cfg = '0;
  logic [BYTE_W-1:0] sync_second_cfg = '0;
  logic [POS_W-1:0]  seen_bytes = '0;
  logic [BYTE_W-1:0] crc_acc = CRC_INIT;
  logic              sync_mismatch = 1'b0;
  logic [LEN_W-1:0]  length_field = '0;
  logic [BYTE_W-1:0] id_field = '0;
  logic [BYTE_W-1:0] checksum_field = '0;

  result_t           pending_reports[$];
  result_t           head_report;
  logic [BYTE_W-1:0] frame_buf[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          err_count = 0;
  int          stuck_cycles = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          reports_checked = 0;

  framed_packet_checker_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .check_status   (check_status),
    .message_id     (message_id),
    .payload_length (payload_length),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // CRC-8 poly 0x07, MSB first
  function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] r;
    r = acc ^ data;
    repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Advance the frame state by one byte; return 1 with the report on a frame end
  function automatic bit track_frame_byte(input logic [BYTE_W-1:0] data, input logic last,
                                          output result_t rep);
    logic [POS_W-1:0] size_needed;
    rep = NONE;
    case (seen_bytes)
      POS_SYNC_FIRST: begin
        if (data != sync_first_cfg) sync_mismatch = 1'b1;
      end
      POS_SYNC_SECOND: begin
        if (data != sync_second_cfg) sync_mismatch = 1'b1;
      end
      POS_LEN_LOW: begin
        length_field[7:0] = data;
        crc_acc = crc8_next(crc_acc, data);
      end
      POS_LEN_HIGH: begin
        length_field[15:8] = data;
        crc_acc = crc8_next(crc_acc, data);
      end
      POS_MSG_ID: begin
        id_field = data;
        crc_acc = crc8_next(crc_acc, data);
      end
      POS_CHECKSUM: begin
        checksum_field = data;
      end
      default: begin
        crc_acc = crc8_next(crc_acc, data);
      end
    endcase
    if (seen_bytes != POS_MAX) seen_bytes = seen_bytes + 1'b1;
    if (!last) return 1'b0;

    size_needed = {1'b0, length_field} + HEADER_BYTES;
    if (seen_bytes < HEADER_BYTES) begin
      rep = '{ST_SIZE, 8'h00, 16'h0000};
    end else begin
      rep.id = id_field;
      rep.length = length_field;
      if (sync_mismatch) rep.status = ST_SYNC;
      else if (id_field == 8'h00) rep.status = ST_ID;
      else if (seen_bytes != size_needed) rep.status = ST_SIZE;
      else if (crc_acc != checksum_field) rep.status = ST_CRC;
      else rep.status = ST_OK;
    end
    // clear for the next frame
    seen_bytes = '0;
    crc_acc = CRC_INIT;
    sync_mismatch = 1'b0;
    length_field = '0;
    id_field = '0;
    checksum_field = '0;
    return 1'b1;
  endfunction

  // Drive one byte, hold it until accepted, then log the expected report on a frame end
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last,
                           input logic typed, input result_t want);
    result_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= data;
    frame_end  <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (track_frame_byte(data, last, rep)) pending_reports.push_back(typed ? want : rep);
  endtask

  task automatic send_buffered_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1, 1'b0, NONE);
    end
    frames_sent++;
  endtask

  // Drain all reports, let the pipeline empty, then load both sync registers
  task automatic write_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    sync_first_cfg = first;
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data  <= second;
    @(posedge clk);
    sync_second_cfg = second;
    cfg_we <= 1'b0;
  endtask

  // Build one frame: mostly well formed, some broken, some short noise
  task automatic build_random_frame();
    int               pick;
    int               n;
    logic [LEN_W-1:0] plen;
    logic [BYTE_W-1:0] acc;
    frame_buf.delete();
    pick = $urandom_range(99);
    if (pick < 70) begin
      plen = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(64)) : LEN_W'($urandom_range(8));
      frame_buf.push_back(($urandom_range(19) == 0) ?
                          sync_first_cfg ^ BYTE_W'($urandom_range(1, 255)) : sync_first_cfg);
      frame_buf.push_back(($urandom_range(19) == 0) ?
                          sync_second_cfg ^ BYTE_W'($urandom_range(1, 255)) : sync_second_cfg);
      frame_buf.push_back(plen[7:0]);
      frame_buf.push_back(plen[15:8]);
      frame_buf.push_back(($urandom_range(11) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
      frame_buf.push_back(8'h00);
      for (int i = 0; i < plen; i++) frame_buf.push_back(BYTE_W'($urandom));
      acc = CRC_INIT;
      for (int i = int'(POS_LEN_LOW); i < frame_buf.size(); i++) begin
        if (i != int'(POS_CHECKSUM)) acc = crc8_next(acc, frame_buf[i]);
      end
      frame_buf[POS_CHECKSUM] = ($urandom_range(9) == 0) ?
                                acc ^ BYTE_W'($urandom_range(1, 255)) : acc;
      // occasionally one byte short or one too many
      case ($urandom_range(19))
        0: void'(frame_buf.pop_back());
        1: frame_buf.push_back(BYTE_W'($urandom));
        default: ;
      endcase
    end else if (pick < 88) begin
      n = $urandom_range(6, 24);
      for (int i = 0; i < n; i++) frame_buf.push_back(BYTE_W'($urandom));
      if ($urandom_range(1)) begin
        frame_buf[POS_SYNC_FIRST]  = sync_first_cfg;
        frame_buf[POS_SYNC_SECOND] = sync_second_cfg;
      end
    end else begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) frame_buf.push_back(BYTE_W'($urandom));
    end
  endtask

  task automatic random_traffic(input int byte_budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      build_random_frame();
      send_buffered_frame();
    end
  endtask

  // Check each delivered report against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report with none expected: status %0d id %02h length %04h",
               check_status, message_id, payload_length);
        err_count++;
      end else begin
        head_report = pending_reports.pop_front();
        reports_checked++;
        if (check_status !== head_report.status) begin
          $error("check_status expected %0d got %0d", head_report.status, check_status);
          err_count++;
        end
        if (message_id !== head_report.id) begin
          $error("message_id expected %02h got %02h", head_report.id, message_id);
          err_count++;
        end
        if (payload_length !== head_report.length) begin
          $error("payload_length expected %04h got %04h", head_report.length, payload_length);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  always @(posedge clk) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] rand_first;
    logic [BYTE_W-1:0] rand_second;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: slow receiver, sync 00/00, scripted frames then random
    send_idle_pct = 18;
    recv_idle_pct = 69;
    write_sync(8'h00, 8'h00);
    foreach (SCRIPT[i]) begin
      send_byte(SCRIPT[i].data, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
      if (SCRIPT[i].last) frames_sent++;
    end
    random_traffic(133);

    // Phase 2: slow sender, sync FF/00
    write_sync(8'hFF, 8'h00);
    send_idle_pct = 69;
    recv_idle_pct = 18;
    random_traffic(133);

    // Phase 3: no idling, random sync
    rand_first  = BYTE_W'($urandom);
    rand_second = BYTE_W'($urandom);
    write_sync(rand_first, rand_second);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(134);

    // Drain and let any stray report show up
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d status reports from %0d frames (%0d bytes)",
             reports_checked, frames_sent, bytes_sent);
    $display("under both stall mixes and none; sync settings 00/00, FF/00 and %02h/%02h",
             rand_first, rand_second);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: framed_packet_checker_core.f
design/fpc_pkg.sv
design/fpc_frame.sv
design/fpc_result_reg.sv
design/framed_packet_checker_core.sv
design/fpc_checker.sv
test/tb.sv
